// ----- design/mpbm_pkg.sv -----
// Package for the multimodal pixel background model: sizes, fixed-point
// constants, register codes and the state entry and lane result types.
// No dependencies.
package mpbm_pkg;

   localparam int IDX_W       = 18;
   localparam int PIXELS      = 2 ** IDX_W;
   localparam int CHANNELS    = 3;
   localparam int MODELS      = 3;
   localparam int SAMPLE_W    = 8;
   localparam int VALUE_W     = 16;
   localparam int VALUE_FRAC  = 7;
   localparam int MEAN_W      = VALUE_W - VALUE_FRAC;
   localparam int COUNT_W     = 11;
   localparam int TIME_W      = 10;
   localparam int DIFF_W      = 8;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 10;

   localparam int BLEND_W     = 26;
   localparam int BLEND_S     = 13107;
   localparam int BLEND_V     = 922;
   localparam int BLEND_SHIFT = 10;
   localparam int COUNT_STEP  = 2;

   localparam logic [TIME_W-1:0] TIME_DEFAULT = TIME_W'(20);
   localparam logic [DIFF_W-1:0] DIFF_DEFAULT = DIFF_W'(10);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TIME_THRESHOLD = 1'b0,
      CSR_DIFF_THRESHOLD = 1'b1
   } csr_reg_type;

   typedef logic [IDX_W-1:0]                        pixel_idx_type;
   typedef logic [CHANNELS-1:0][SAMPLE_W-1:0]       pixel_type;
   typedef logic [CHANNELS-1:0][VALUE_W-1:0]        model_value_type;
   typedef logic [COUNT_W-1:0]                      count_type;

   typedef struct packed {
      pixel_type                           last;
      logic [MODELS-1:0][CHANNELS-1:0][VALUE_W-1:0] val;
      logic [MODELS-1:0][COUNT_W-1:0]      cnt;
      pixel_type                           bg;
   } entry_type;

   typedef struct packed {
      logic            match;
      count_type       dec_cnt;
      count_type       inc_cnt;
      model_value_type blend;
   } lane_result_type;

endpackage

// ----- design/mpbm_channels.sv -----
// Channel interfaces of the background model: pixel requests, background
// responses and register writes.
// Depends on mpbm_pkg.
interface mpbm_req_if;
   import mpbm_pkg::*;
   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    pixel_index;
   logic [SAMPLE_W-1:0] sample_0;
   logic [SAMPLE_W-1:0] sample_1;
   logic [SAMPLE_W-1:0] sample_2;
   logic                load_background;
   modport source (output valid, pixel_index, sample_0, sample_1, sample_2, load_background,
                   input ready);
   modport sink   (input valid, pixel_index, sample_0, sample_1, sample_2, load_background,
                   output ready);
endinterface

interface mpbm_rsp_if;
   import mpbm_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] bg_0;
   logic [SAMPLE_W-1:0] bg_1;
   logic [SAMPLE_W-1:0] bg_2;
   logic                bg_changed;
   logic                pixel_stable;
   modport source (output valid, bg_0, bg_1, bg_2, bg_changed, pixel_stable, input ready);
   modport sink   (input valid, bg_0, bg_1, bg_2, bg_changed, pixel_stable, output ready);
endinterface

interface mpbm_csr_if;
   import mpbm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/multimodal_pixel_background_model.sv -----
// Top level of the multimodal pixel background model: per-pixel state memory,
// read pipeline with write forwarding, model lanes, merge and response register.
// Depends on mpbm_pkg, mpbm_channels, mpbm_lane and mpbm_merge.
//
//   channel  | dir | transaction
//   ---------+-----+--------------------------------------------------------
//   req_chan | in  | pixel_index, sample_0..2, load_background
//   rsp_chan | out | bg_0..2, bg_changed, pixel_stable
//   csr_chan | in  | index (0 time_threshold, 1 diff_threshold), data
//
// One pixel per cycle while rsp_chan flows; a request passes through stage 1, stage 2 and
// the response register. The state memory's single read port and its read-modify-write loop
// set that rate; a request for the same pixel as the one just taken waits until it can
// pick up that transaction's state from the write-back.
// After reset a clearing pass zeroes all 262144 entries of the state memory, one entry a
// cycle, during which req_chan.ready is low; csr writes are always taken.
// A stalled response holds the pipeline behind it; two more requests are still taken.
module multimodal_pixel_background_model (
   input logic         clock,
   input logic         reset,
   mpbm_req_if.sink    req_chan,
   mpbm_rsp_if.source  rsp_chan,
   mpbm_csr_if.sink    csr_chan
);
   import mpbm_pkg::*;

   entry_type state_mem [PIXELS];

   logic [TIME_W-1:0] time_thr_ff, time_thr_in;
   logic [DIFF_W-1:0] diff_thr_ff, diff_thr_in;

   logic          clr_ff, clr_in;
   pixel_idx_type clr_addr_ff, clr_addr_in;

   logic          p1_valid_ff, p1_valid_in;
   pixel_idx_type p1_pixel_ff, p1_pixel_in;
   pixel_type     p1_sample_ff, p1_sample_in;
   logic          p1_load_ff, p1_load_in;
   entry_type     rd_data_ff;
   logic          fwd_hit_ff, fwd_hit_in;
   entry_type     fwd_data_ff, fwd_data_in;

   logic          p2_valid_ff, p2_valid_in;
   pixel_idx_type p2_pixel_ff, p2_pixel_in;
   pixel_type     p2_sample_ff, p2_sample_in;
   logic          p2_load_ff, p2_load_in;
   logic          p2_stable_ff, p2_stable_in;
   logic [MODELS-1:0][CHANNELS-1:0][VALUE_W-1:0] p2_values_ff, p2_values_in;
   pixel_type     p2_bg_ff, p2_bg_in;
   lane_result_type [MODELS-1:0] p2_lanes_ff, p2_lanes_in;

   logic          rsp_valid_ff, rsp_valid_in;
   pixel_type     rsp_bg_ff, rsp_bg_in;
   logic          rsp_changed_ff, rsp_changed_in;
   logic          rsp_stable_ff, rsp_stable_in;

   pixel_type     req_sample;
   logic          out_en;
   logic          p2_load;
   logic          hazard;
   logic          req_ready;
   logic          accept;
   logic          wr_en;
   pixel_idx_type wr_addr;
   entry_type     wr_data;
   entry_type     cur;
   logic          p1_stable;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] last_dist;
   lane_result_type [MODELS-1:0] lane_res;
   entry_type     merged;
   logic          merged_changed;

   assign req_sample = {req_chan.sample_2, req_chan.sample_1, req_chan.sample_0};

   // handshake and pipeline control
   assign out_en  = p2_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign p2_load = p1_valid_ff && (!p2_valid_ff || out_en);
   assign hazard  = (p1_valid_ff && req_chan.pixel_index == p1_pixel_ff)
                 || (p2_valid_ff && !out_en && req_chan.pixel_index == p2_pixel_ff);
   assign req_ready = !clr_ff && (!p1_valid_ff || p2_load) && !hazard;
   assign accept    = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   // configuration
   always_comb begin
      time_thr_in = time_thr_ff;
      diff_thr_in = diff_thr_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_TIME_THRESHOLD: begin
               time_thr_in = (csr_chan.data[TIME_W-1:0] == '0) ? TIME_DEFAULT
                                                              : csr_chan.data[TIME_W-1:0];
            end
            CSR_DIFF_THRESHOLD: begin
               diff_thr_in = (csr_chan.data[DIFF_W-1:0] == '0) ? DIFF_DEFAULT
                                                              : csr_chan.data[DIFF_W-1:0];
            end
            default: begin
               time_thr_in = time_thr_ff;
            end
         endcase
      end
   end

   // clearing pass
   assign clr_in      = clr_ff && (clr_addr_ff != IDX_W'(PIXELS - 1));
   assign clr_addr_in = clr_ff ? clr_addr_ff + IDX_W'(1) : clr_addr_ff;

   // memory write port
   assign wr_en   = clr_ff || out_en;
   assign wr_addr = clr_ff ? clr_addr_ff : p2_pixel_ff;
   assign wr_data = clr_ff ? '0 : merged;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= state_mem[req_chan.pixel_index];
      end
   end

   // stage 1: forwarded state, stability, lanes
   assign p1_valid_in  = accept ? 1'b1 : (p2_load ? 1'b0 : p1_valid_ff);
   assign p1_pixel_in  = accept ? req_chan.pixel_index : p1_pixel_ff;
   assign p1_sample_in = accept ? req_sample : p1_sample_ff;
   assign p1_load_in   = accept ? req_chan.load_background : p1_load_ff;
   assign fwd_hit_in   = accept ? (out_en && p2_pixel_ff == req_chan.pixel_index) : fwd_hit_ff;
   assign fwd_data_in  = accept ? merged : fwd_data_ff;

   assign cur = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   always_comb begin
      p1_stable = 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
         last_dist[c] = (p1_sample_ff[c] > cur.last[c]) ? p1_sample_ff[c] - cur.last[c]
                                                        : cur.last[c] - p1_sample_ff[c];
         if (last_dist[c] > (diff_thr_ff >> 1)) begin
            p1_stable = 1'b0;
         end
      end
   end

   for (genvar k = 0; k < MODELS; k++) begin : g_lane
      mpbm_lane u_lane (
         .sample   (p1_sample_ff),
         .value    (cur.val[k]),
         .count    (cur.cnt[k]),
         .stable   (p1_stable),
         .time_thr (time_thr_ff),
         .diff_thr (diff_thr_ff),
         .result   (lane_res[k])
      );
   end

   // stage 2: merge and write back
   assign p2_valid_in  = p2_load ? 1'b1 : (out_en ? 1'b0 : p2_valid_ff);
   assign p2_pixel_in  = p2_load ? p1_pixel_ff : p2_pixel_ff;
   assign p2_sample_in = p2_load ? p1_sample_ff : p2_sample_ff;
   assign p2_load_in   = p2_load ? p1_load_ff : p2_load_ff;
   assign p2_stable_in = p2_load ? p1_stable : p2_stable_ff;
   assign p2_values_in = p2_load ? cur.val : p2_values_ff;
   assign p2_bg_in     = p2_load ? cur.bg : p2_bg_ff;
   assign p2_lanes_in  = p2_load ? lane_res : p2_lanes_ff;

   mpbm_merge u_merge (
      .sample     (p2_sample_ff),
      .load       (p2_load_ff),
      .stable     (p2_stable_ff),
      .values     (p2_values_ff),
      .bg_old     (p2_bg_ff),
      .lanes      (p2_lanes_ff),
      .time_thr   (time_thr_ff),
      .next_entry (merged),
      .changed    (merged_changed)
   );

   // response register
   assign rsp_valid_in   = out_en ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_bg_in      = out_en ? merged.bg : rsp_bg_ff;
   assign rsp_changed_in = out_en ? merged_changed : rsp_changed_ff;
   assign rsp_stable_in  = out_en ? p2_stable_ff : rsp_stable_ff;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.bg_0         = rsp_bg_ff[0];
   assign rsp_chan.bg_1         = rsp_bg_ff[1];
   assign rsp_chan.bg_2         = rsp_bg_ff[2];
   assign rsp_chan.bg_changed   = rsp_changed_ff;
   assign rsp_chan.pixel_stable = rsp_stable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_thr_ff  <= TIME_DEFAULT;
         diff_thr_ff  <= DIFF_DEFAULT;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         time_thr_ff  <= time_thr_in;
         diff_thr_ff  <= diff_thr_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_pixel_ff    <= p1_pixel_in;
      p1_sample_ff   <= p1_sample_in;
      p1_load_ff     <= p1_load_in;
      fwd_data_ff    <= fwd_data_in;
      p2_pixel_ff    <= p2_pixel_in;
      p2_sample_ff   <= p2_sample_in;
      p2_load_ff     <= p2_load_in;
      p2_stable_ff   <= p2_stable_in;
      p2_values_ff   <= p2_values_in;
      p2_bg_ff       <= p2_bg_in;
      p2_lanes_ff    <= p2_lanes_in;
      rsp_bg_ff      <= rsp_bg_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_stable_ff  <= rsp_stable_in;
   end

endmodule

// ----- design/mpbm_lane.sv -----
// One model lane: match test, count decay and increment, and the blend of
// the sample into the model value.
// Depends on mpbm_pkg.
module mpbm_lane (
   input  mpbm_pkg::pixel_type                 sample,
   input  mpbm_pkg::model_value_type           value,
   input  mpbm_pkg::count_type                 count,
   input  logic                                stable,
   input  logic [mpbm_pkg::TIME_W-1:0]         time_thr,
   input  logic [mpbm_pkg::DIFF_W-1:0]         diff_thr,
   output mpbm_pkg::lane_result_type           result
);
   import mpbm_pkg::*;

   logic [CHANNELS-1:0][MEAN_W-1:0]  mean;
   logic [CHANNELS-1:0][MEAN_W-1:0]  samp;
   logic [CHANNELS-1:0][MEAN_W-1:0]  ch_gap;
   logic [CHANNELS-1:0]              ch_ok;
   logic [CHANNELS-1:0][BLEND_W-1:0] blend_sum;
   count_type                        dec_cnt;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         mean[c]      = value[c][VALUE_W-1:VALUE_FRAC];
         samp[c]      = MEAN_W'(sample[c]);
         ch_gap[c]    = (samp[c] > mean[c]) ? samp[c] - mean[c] : mean[c] - samp[c];
         ch_ok[c]     = ch_gap[c] <= MEAN_W'(diff_thr);
         blend_sum[c] = BLEND_W'(sample[c]) * BLEND_W'(BLEND_S)
                      + BLEND_W'(value[c]) * BLEND_W'(BLEND_V);
      end
   end

   assign dec_cnt = (stable && count != '0) ? count - COUNT_W'(1) : count;

   always_comb begin
      result.match   = &ch_ok;
      result.dec_cnt = dec_cnt;
      result.inc_cnt = (dec_cnt < {time_thr, 1'b0}) ? dec_cnt + COUNT_W'(COUNT_STEP) : dec_cnt;
      for (int c = 0; c < CHANNELS; c++) begin
         result.blend[c] = blend_sum[c][BLEND_SHIFT +: VALUE_W];
      end
   end

endmodule

// ----- design/mpbm_merge.sv -----
// Merge of the lane results for a stable pixel: first matching model wins, otherwise the
// first empty model is seeded; if a model matched, the dominant model is copied to background.
// Depends on mpbm_pkg.
module mpbm_merge (
   input  mpbm_pkg::pixel_type                          sample,
   input  logic                                         load,
   input  logic                                         stable,
   input  logic [mpbm_pkg::MODELS-1:0][mpbm_pkg::CHANNELS-1:0][mpbm_pkg::VALUE_W-1:0] values,
   input  mpbm_pkg::pixel_type                          bg_old,
   input  mpbm_pkg::lane_result_type [mpbm_pkg::MODELS-1:0] lanes,
   input  logic [mpbm_pkg::TIME_W-1:0]                  time_thr,
   output mpbm_pkg::entry_type                          next_entry,
   output logic                                         changed
);
   import mpbm_pkg::*;

   logic            found;
   logic            seeded;
   logic            dom;
   model_value_type seed;
   logic [MODELS-1:0][COUNT_W-1:0]               cnt;
   logic [MODELS-1:0][CHANNELS-1:0][VALUE_W-1:0] val;
   pixel_type       bg;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         seed[c] = VALUE_W'(sample[c]) << VALUE_FRAC;
      end
   end

   always_comb begin
      found   = 1'b0;
      seeded  = 1'b0;
      dom     = 1'b0;
      changed = 1'b0;
      val     = values;
      bg      = load ? sample : bg_old;
      for (int k = 0; k < MODELS; k++) begin
         cnt[k] = lanes[k].dec_cnt;
      end
      for (int k = 0; k < MODELS; k++) begin
         if (stable && !found && lanes[k].match) begin
            found  = 1'b1;
            cnt[k] = lanes[k].inc_cnt;
            val[k] = lanes[k].blend;
         end
      end
      for (int k = 0; k < MODELS; k++) begin
         if (stable && !found && !seeded && lanes[k].dec_cnt == '0) begin
            seeded = 1'b1;
            cnt[k] = COUNT_W'(1);
            val[k] = seed;
         end
      end
      // last dominant model in slot order wins
      for (int k = 0; k < MODELS; k++) begin
         dom = found && (cnt[k] > COUNT_W'(time_thr));
         for (int l = 0; l < MODELS; l++) begin
            if (l != k && cnt[k] < cnt[l]) begin
               dom = 1'b0;
            end
         end
         if (dom) begin
            changed = 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
               bg[c] = val[k][c][VALUE_FRAC +: SAMPLE_W];
            end
         end
      end
   end

   always_comb begin
      next_entry.last = sample;
      next_entry.val  = val;
      next_entry.cnt  = cnt;
      next_entry.bg   = bg;
   end

endmodule
